@@ rtl/lrn_pkg.sv @@
// Shared types, constants and lookup functions for the LCD row number renderer.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package lrn_pkg;

  localparam int unsigned DisplayRamWordsDefault = 32;
  localparam int unsigned QueueDepth             = 4;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned NibW   = 4;
  localparam int unsigned ValueW = 20;

  // Reciprocal of ten scaled by 2^23, exact for all 20-bit values.
  localparam logic [19:0] RecipTen   = 20'd838861;
  localparam int unsigned RecipShift = 23;

  localparam logic [1:0] RowNone = 2'd0;
  localparam logic [1:0] Row1    = 2'd1;
  localparam logic [1:0] Row2    = 2'd2;
  localparam logic [1:0] Row3    = 2'd3;

  localparam logic [1:0] PointNone = 2'd0;
  localparam logic [1:0] Point1    = 2'd1;
  localparam logic [1:0] Point2    = 2'd2;
  localparam logic [1:0] Point3    = 2'd3;

  localparam logic [2:0] SegLast     = 3'd6;
  localparam logic [2:0] SegWordLast = 3'd2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIGIT,
    F_POINT
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } back_state_e;

  typedef enum logic {
    K_DIGIT,
    K_POINT
  } entry_kind_e;

  // One queued job: a whole digit place or a single decimal point.
  typedef struct packed {
    entry_kind_e      kind;
    logic [AddrW-1:0] addr;   // digit base word, or point word
    logic [6:0]       code;   // segments A..G in bits 0..6
    logic [1:0]       pbit;   // point bit inside its word
    logic             last;   // final job of the item
  } entry_t;

  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] c;
    case (digit)
      4'd0:    c = 7'h3F;
      4'd1:    c = 7'h06;
      4'd2:    c = 7'h5B;
      4'd3:    c = 7'h4F;
      4'd4:    c = 7'h66;
      4'd5:    c = 7'h6D;
      4'd6:    c = 7'h7D;
      4'd7:    c = 7'h07;
      4'd8:    c = 7'h7F;
      4'd9:    c = 7'h6F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic seg_word_off(input logic [2:0] seg);
    return (seg >= 3'd3);
  endfunction

  function automatic logic [1:0] seg_bit(input logic [2:0] seg);
    logic [1:0] b;
    case (seg)
      3'd0:    b = 2'd0;
      3'd1:    b = 2'd1;
      3'd2:    b = 2'd2;
      3'd3:    b = 2'd3;
      3'd4:    b = 2'd2;
      3'd5:    b = 2'd0;
      3'd6:    b = 2'd1;
      default: b = 2'd0;
    endcase
    return b;
  endfunction

  function automatic logic [AddrW-1:0] point_word(input logic [1:0] row, input logic [1:0] pos);
    logic [AddrW-1:0] w;
    case ({row, pos})
      {Row1, Point1}: w = 5'd26;
      {Row1, Point2}: w = 5'd23;
      {Row1, Point3}: w = 5'd22;
      {Row2, Point1}: w = 5'd16;
      {Row2, Point2}: w = 5'd14;
      {Row2, Point3}: w = 5'd12;
      {Row3, Point1}: w = 5'd4;
      {Row3, Point2}: w = 5'd2;
      {Row3, Point3}: w = 5'd0;
      default:        w = 5'd0;
    endcase
    return w;
  endfunction

  function automatic logic [1:0] point_bit(input logic [1:0] row, input logic [1:0] pos);
    logic [1:0] b;
    case ({row, pos})
      {Row1, Point2}: b = 2'd2;
      default:        b = 2'd3;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/lrn_front.sv @@
// Front end: accepts items, splits the value one digit place per cycle while the
// queue has room, queuing a job per place and an optional point job. Uses lrn_pkg.
module lrn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          row_select_i,
  input  logic [19:0]         number_value_i,
  input  logic [1:0]          point_position_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output lrn_pkg::entry_t     push_data_o
);
  import lrn_pkg::*;

  front_state_e state_q, state_d;

  logic [ValueW-1:0] value_q;
  logic [2:0]        place_q;
  logic [AddrW-1:0]  top_q;
  logic [1:0]        row_q;
  logic [1:0]        point_q;
  logic              first_q;

  logic [39:0]       prod;
  logic [ValueW-1:0] quot;
  logic [ValueW-1:0] tens;
  logic [ValueW-1:0] rem_full;
  logic [3:0]        digit;
  logic              show;
  logic              accept;
  logic              load;

  assign prod     = 40'(value_q) * 40'(RecipTen);
  assign quot     = ValueW'(prod[39:RecipShift]);
  assign tens     = {quot[16:0], 3'b000} + {quot[18:0], 1'b0};
  assign rem_full = value_q - tens;
  assign digit    = rem_full[3:0];
  assign show     = first_q || (value_q != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && row_select_i != RowNone) state_d = F_DIGIT;
      end
      F_DIGIT: begin
        if (push_ready_i && place_q == 3'd0) begin
          state_d = (point_q != PointNone) ? F_POINT : F_IDLE;
        end
      end
      F_POINT: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    push_data_o  = '0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
      end
      F_DIGIT: begin
        push_valid_o      = 1'b1;
        push_data_o.kind  = K_DIGIT;
        push_data_o.addr  = top_q - {1'b0, place_q, 1'b0};
        push_data_o.code  = show ? seg_code(digit) : 7'h00;
        push_data_o.last  = (place_q == 3'd0) && (point_q == PointNone);
      end
      F_POINT: begin
        push_valid_o      = 1'b1;
        push_data_o.kind  = K_POINT;
        push_data_o.addr  = point_word(row_q, point_q);
        push_data_o.pbit  = point_bit(row_q, point_q);
        push_data_o.last  = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign load   = accept && (row_select_i != RowNone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= number_value_i;
      row_q   <= row_select_i;
      point_q <= point_position_i;
      first_q <= 1'b1;
      place_q <= (row_select_i == Row3) ? 3'd5 : 3'd4;
      case (row_select_i)
        Row1:    top_q <= 5'd30;
        Row2:    top_q <= 5'd20;
        default: top_q <= 5'd10;
      endcase
    end else if (state_q == F_DIGIT && push_ready_i) begin
      // A blanked place leaves value at zero, so the quotient is right either way.
      value_q <= quot;
      first_q <= 1'b0;
      place_q <= place_q - 3'd1;
    end
  end

endmodule

@@ rtl/lrn_queue.sv @@
// Short job queue between the front end and the back end.
// Holds lrn_pkg::entry_t jobs; depth comes from lrn_pkg.
module lrn_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  lrn_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output lrn_pkg::entry_t pop_data_o
);
  import lrn_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ rtl/lrn_back.sv @@
// Back end: runs queued jobs against the shadow display memory, one segment
// write per beat, and drives the result output register. Uses lrn_pkg.
module lrn_back #(
  parameter int unsigned DISPLAY_RAM_WORDS = lrn_pkg::DisplayRamWordsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_pop_o,
  input  lrn_pkg::entry_t           job_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lrn_pkg::AddrW-1:0] ram_address_o,
  output logic [lrn_pkg::NibW-1:0]  ram_nibble_o,
  output logic                      last_write_o
);
  import lrn_pkg::*;

  localparam int unsigned IdxW = $clog2(DISPLAY_RAM_WORDS);

  back_state_e state_q, state_d;

  logic [NibW-1:0]          mem [DISPLAY_RAM_WORDS];
  logic [DISPLAY_RAM_WORDS-1:0] valid_q;
  logic [NibW-1:0]          rdata_q;
  logic                     rvalid_q;

  entry_t                   ent_q;
  logic [2:0]               seg_q;
  logic [NibW-1:0]          nib_q;
  logic                     fresh_q;

  logic                     out_valid_q;
  logic [AddrW-1:0]         out_addr_q;
  logic [NibW-1:0]          out_nib_q;
  logic                     out_last_q;

  logic                     is_point;
  logic [AddrW-1:0]         word_addr;
  logic [IdxW-1:0]          word_idx;
  logic [1:0]               bit_sel;
  logic [NibW-1:0]          mask;
  logic                     seg_on;
  logic [NibW-1:0]          cur_nib;
  logic [NibW-1:0]          new_nib;
  logic                     out_free;
  logic                     emit;
  logic                     item_done;
  logic                     word_done;
  logic                     pop;

  assign is_point  = (ent_q.kind == K_POINT);
  assign word_addr = is_point ? ent_q.addr : ent_q.addr + AddrW'(seg_word_off(seg_q));
  assign word_idx  = IdxW'(word_addr);
  assign bit_sel   = is_point ? ent_q.pbit : seg_bit(seg_q);
  assign mask      = NibW'(1) << bit_sel;
  assign seg_on    = is_point ? 1'b1 : ent_q.code[seg_q];
  // Never-written words read as the reset value.
  assign cur_nib   = fresh_q ? (rvalid_q ? rdata_q : '0) : nib_q;
  assign new_nib   = seg_on ? (cur_nib | mask) : (cur_nib & ~mask);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    emit      = 1'b0;
    item_done = 1'b0;
    word_done = 1'b0;
    pop       = 1'b0;
    case (state_q)
      B_IDLE: begin
        pop = job_valid_i;
      end
      B_EMIT: begin
        emit      = out_free;
        item_done = out_free && (is_point || seg_q == SegLast);
        word_done = out_free && !is_point && seg_q == SegWordLast;
        pop       = item_done && job_valid_i;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) state_d = B_READ;
      end
      B_READ: begin
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (item_done) begin
          state_d = job_valid_i ? B_READ : B_IDLE;
        end else if (word_done) begin
          state_d = B_READ;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign job_pop_o     = pop;
  assign out_valid_o   = out_valid_q;
  assign ram_address_o = out_addr_q;
  assign ram_nibble_o  = out_nib_q;
  assign last_write_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      fresh_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q       <= 1'b1;
        valid_q[word_idx] <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == B_READ) begin
        fresh_q <= 1'b1;
      end else if (emit) begin
        fresh_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ent_q <= job_i;
      seg_q <= '0;
    end else if (emit && !item_done) begin
      seg_q <= seg_q + 3'd1;
    end
    if (emit) begin
      nib_q      <= new_nib;
      out_addr_q <= word_addr;
      out_nib_q  <= new_nib;
      out_last_q <= ent_q.last && item_done;
    end
  end

  // Shadow display memory: one read port, one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == B_READ) begin
      rdata_q  <= mem[word_idx];
      rvalid_q <= valid_q[word_idx];
    end
    if (emit) mem[word_idx] <= new_nib;
  end

endmodule

@@ rtl/lcd_row_number_renderer.sv @@
// Top level of the LCD row number renderer: front end, job queue, back end.
// Depends on lrn_pkg, lrn_front, lrn_queue and lrn_back.
//
// Takes one item (row, value, decimal point) per beat and writes the value as
// right-aligned seven-segment digits into a shadow display memory, emitting one
// beat per segment write (address and new nibble, tlast on the item's final
// write). Rows 1 and 2 have five digit places, row 3 six; leading zeros blank,
// the rightmost digit always shows. Row 0 items are taken and produce nothing.
// The back end reads each display word once from the shadow memory, then
// writes its segments one beat each; a digit place spans two display words
// and a point one. The front end splits the value into digits at one per
// cycle, while the four-entry queue has room, and accepts the next item once
// the previous item's jobs are all queued. Shadow memory reads as zero after
// reset through per-word valid bits, so no clearing pass is needed.
module lcd_row_number_renderer #(
  parameter int unsigned DISPLAY_RAM_WORDS = lrn_pkg::DisplayRamWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] row_select, [21:2] number_value, [23:22] point_position
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] ram_address, [8:5] ram_nibble, [15:9] zero
  output logic [15:0] m_axis_tdata,
  // last_write
  output logic        m_axis_tlast
);
  import lrn_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   job_valid;
  logic   job_pop;
  entry_t job;

  logic [AddrW-1:0] ram_address;
  logic [NibW-1:0]  ram_nibble;

  lrn_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .row_select_i     (s_axis_tdata[1:0]),
    .number_value_i   (s_axis_tdata[21:2]),
    .point_position_i (s_axis_tdata[23:22]),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_data_o      (push_data)
  );

  lrn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop),
    .pop_data_o   (job)
  );

  lrn_back #(
    .DISPLAY_RAM_WORDS (DISPLAY_RAM_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_pop_o     (job_pop),
    .job_i         (job),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .ram_address_o (ram_address),
    .ram_nibble_o  (ram_nibble),
    .last_write_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, ram_nibble, ram_address};

endmodule
